// ----- design/dpi_pkg.sv -----
// Shared types, constants and tables for the damped particle integrator.
// No dependencies.
package dpi_pkg;

    localparam int unsigned NumLanes = 3;
    localparam logic [31:0] ONE_Q16 = 32'd65536;

    // item kinds
    typedef enum logic [1:0] {
        KIND_FORCE = 2'd0,
        KIND_STEP  = 2'd1,
        KIND_POS   = 2'd2,
        KIND_VEL   = 2'd3
    } kind_t;

    // register indexes
    localparam logic [2:0] REG_INV_MASS = 3'd0;
    localparam logic [2:0] REG_DAMPING  = 3'd1;
    localparam logic [2:0] REG_ACCEL_X  = 3'd2;
    localparam logic [2:0] REG_ACCEL_Y  = 3'd3;
    localparam logic [2:0] REG_ACCEL_Z  = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_EXP,
        ST_FAC,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_OUT
    } state_t;

    // per-lane control from the sequencer
    typedef struct packed {
        logic load;     // latch inputs of a new item
        logic p1;       // pos update, force*inv_mass
        logic p2;       // acc, vel + acc*dur
        logic p3;       // damping multiply, clear force
    } lane_ctl_t;

    function automatic logic [16:0] log_tab(input logic [4:0] i);
        case (i)
            5'd0:  log_tab = 17'd0;
            5'd1:  log_tab = 17'd5732;
            5'd2:  log_tab = 17'd11136;
            5'd3:  log_tab = 17'd16248;
            5'd4:  log_tab = 17'd21098;
            5'd5:  log_tab = 17'd25711;
            5'd6:  log_tab = 17'd30109;
            5'd7:  log_tab = 17'd34312;
            5'd8:  log_tab = 17'd38336;
            5'd9:  log_tab = 17'd42196;
            5'd10: log_tab = 17'd45904;
            5'd11: log_tab = 17'd49472;
            5'd12: log_tab = 17'd52910;
            5'd13: log_tab = 17'd56228;
            5'd14: log_tab = 17'd59434;
            5'd15: log_tab = 17'd62534;
            default: log_tab = 17'd65536;
        endcase
    endfunction

    function automatic logic [17:0] exp_tab(input logic [4:0] i);
        case (i)
            5'd0:  exp_tab = 18'd65536;
            5'd1:  exp_tab = 18'd68438;
            5'd2:  exp_tab = 18'd71468;
            5'd3:  exp_tab = 18'd74632;
            5'd4:  exp_tab = 18'd77936;
            5'd5:  exp_tab = 18'd81386;
            5'd6:  exp_tab = 18'd84990;
            5'd7:  exp_tab = 18'd88752;
            5'd8:  exp_tab = 18'd92682;
            5'd9:  exp_tab = 18'd96785;
            5'd10: exp_tab = 18'd101070;
            5'd11: exp_tab = 18'd105545;
            5'd12: exp_tab = 18'd110218;
            5'd13: exp_tab = 18'd115098;
            5'd14: exp_tab = 18'd120193;
            5'd15: exp_tab = 18'd125515;
            default: exp_tab = 18'd131072;
        endcase
    endfunction

    // saturate a signed 34-bit sum to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            sat34 = 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            sat34 = 32'sh80000000;
        else
            sat34 = v[31:0];
    endfunction

    // saturate a signed 50-bit value to 32 bits
    function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
        if (v > 50'sd2147483647)
            sat50 = 32'sh7fffffff;
        else if (v < -50'sd2147483648)
            sat50 = 32'sh80000000;
        else
            sat50 = v[31:0];
    endfunction

    // round(|a|*b/2^16) half away from zero, signed result; b up to 32 bits
    function automatic logic signed [49:0] mul_q16(input logic signed [31:0] a,
                                                   input logic [31:0] b);
        logic [31:0] mag;
        logic [63:0] prod;
        logic [47:0] q;
        mag = a[31] ? (32'd0 - a) : a;
        prod = mag * b + 64'd32768;
        q = prod[63:16];
        mul_q16 = a[31] ? -$signed({2'b00, q}) : $signed({2'b00, q});
    endfunction

endpackage

// ----- design/dpi_if.sv -----
// Valid/ready channel interfaces for the damped particle integrator.
// No dependencies.
interface dpi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] vec_x;
    logic [31:0] vec_y;
    logic [31:0] vec_z;
    logic [23:0] duration;
    modport source (output valid, kind, vec_x, vec_y, vec_z, duration, input ready);
    modport sink   (input valid, kind, vec_x, vec_y, vec_z, duration, output ready);
endinterface

interface dpi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic        bad_step;
    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, bad_step,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, bad_step,
                    output ready);
endinterface

interface dpi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/dpi_damp.sv -----
// Damping factor unit: damping^duration through log2/exp2 tables, in log, exp, exp-table and scale steps.
// Depends on dpi_pkg.
module dpi_damp (
    input  logic        clk,
    input  logic        start,      // with damping/duration valid
    input  logic        step_exp,
    input  logic        step_fac,
    input  logic [16:0] damping,
    input  logic [23:0] duration,
    output logic [16:0] factor
);

    logic [20:0] l_reg;
    logic [31:0] e_reg;
    logic [17:0] x_reg;
    logic        zero_reg;
    logic        one_reg;
    logic [16:0] factor_reg;

    // log stage: normalize and look up
    logic [3:0]  p;
    logic [16:0] m;
    logic [15:0] frac;
    logic [4:0]  li;
    logic [11:0] lr;
    logic [16:0] lg;
    logic [28:0] ld;
    logic [20:0] lfull;

    function automatic logic [16:0] log_diff(input logic [4:0] i);
        log_diff = dpi_pkg::log_tab(5'(i + 5'd1)) - dpi_pkg::log_tab(i);
    endfunction

    always_comb
    begin
        p = 4'd0;
        for (int k = 0; k < 16; k++)
        begin
            if (damping[k])
                p = 4'(k);
        end
        m = 17'(damping << (5'd16 - {1'b0, p}));
        frac = m[15:0];
        li = {1'b0, frac[15:12]};
        lr = frac[11:0];
        ld = 29'((log_diff(li) * lr) + 29'd2048);
        lg = 17'(dpi_pkg::log_tab(li) + 17'(ld >> 12));
        lfull = (21'({5'd0, 5'd16 - {1'b0, p}}) << 16) - 21'(lg);
    end

    // exp stage operands
    logic [47:0] eprod;
    logic [15:0] f;
    logic [16:0] g;
    logic [4:0]  gi;
    logic [11:0] gr;
    logic [29:0] xd;
    logic [17:0] xv;
    logic [17:0] ediff;

    always_comb
    begin
        f = e_reg[15:0];
        g = 17'd65536 - {1'b0, f};
        gi = g[16:12];
        gr = g[11:0];
        ediff = dpi_pkg::exp_tab(5'(gi + 5'd1)) - dpi_pkg::exp_tab(gi);
        xd = 30'(ediff * gr) + 30'd2048;
        if (gi >= 5'd16)
            xv = dpi_pkg::exp_tab(5'd16);
        else
            xv = dpi_pkg::exp_tab(gi) + 18'(xd >> 12);
    end

    // final scale
    logic [15:0] n;
    logic [16:0] s;
    logic [17:0] rnd;
    logic [18:0] xs;

    always_comb
    begin
        n = 16'(e_reg >> 16);
        s = {1'b0, n} + 17'd1;
        rnd = (s >= 17'd19) ? 18'd0 : 18'(18'd1 << (s - 17'd1));
        xs = ({1'b0, x_reg} + {1'b0, rnd}) >> s;
    end

    // e = round(L*dur/2^16), L fits 21 bits so product is 45 bits
    assign eprod = (48'(l_reg) * 48'(duration)) + 48'd32768;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            l_reg    <= lfull;
            zero_reg <= (damping == 17'd0);
            one_reg  <= damping[16];
        end
        if (step_exp)
            e_reg <= eprod[47:16];
        if (step_fac)
        begin
            if (one_reg)
                factor_reg <= 17'd65536;
            else if (zero_reg || s >= 17'd40)
                factor_reg <= 17'd0;
            else
                factor_reg <= 17'(xs);
        end
    end

    // x computed from e in its own cycle
    logic x_en;
    assign x_en = step_fac;
    always_ff @(posedge clk)
    begin
        if (!x_en && !step_exp && !start)
            x_reg <= xv;
    end

    assign factor = factor_reg;

endmodule

// ----- design/dpi_lane.sv -----
// One component lane: position, velocity and force registers and their update.
// Depends on dpi_pkg.
module dpi_lane (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpi_pkg::lane_ctl_t   ctl,
    input  logic [1:0]           kind,
    input  logic                 do_step,
    input  logic signed [31:0]   vec,
    input  logic [23:0]          duration,
    input  logic [31:0]          inv_mass,
    input  logic signed [31:0]   accel,
    input  logic [16:0]          factor,
    output logic signed [31:0]   pos,
    output logic signed [31:0]   vel
);

    logic signed [31:0] pos_reg, vel_reg, frc_reg;
    logic signed [31:0] fm_reg, nv_reg;

    logic signed [31:0] pos_next, fm_next, nv_next, vel_next, acc;

    always_comb
    begin
        pos_next = dpi_pkg::sat50(50'(pos_reg) + dpi_pkg::mul_q16(vel_reg, 32'(duration)));
        fm_next  = dpi_pkg::sat50(dpi_pkg::mul_q16(frc_reg, inv_mass));
        acc      = dpi_pkg::sat34(34'(accel) + 34'(fm_reg));
        nv_next  = dpi_pkg::sat50(50'(vel_reg) + dpi_pkg::mul_q16(acc, 32'(duration)));
        vel_next = dpi_pkg::sat50(dpi_pkg::mul_q16(nv_reg, 32'(factor)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vel_reg <= '0;
            frc_reg <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                case (dpi_pkg::kind_t'(kind))
                    dpi_pkg::KIND_FORCE: frc_reg <= dpi_pkg::sat34(34'(frc_reg) + 34'(vec));
                    dpi_pkg::KIND_POS:   pos_reg <= vec;
                    dpi_pkg::KIND_VEL:   vel_reg <= vec;
                    default: ;
                endcase
            end
            if (ctl.p1 && do_step)
                pos_reg <= pos_next;
            if (ctl.p3 && do_step)
            begin
                vel_reg <= vel_next;
                frc_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.p1)
            fm_reg <= fm_next;
        if (ctl.p2)
            nv_reg <= nv_next;
    end

    assign pos = pos_reg;
    assign vel = vel_reg;

endmodule

// ----- design/damped_particle_integrator_unit.sv -----
// Top level of the damped particle integrator: sequencer, damping unit,
// three lanes and output merge. Depends on dpi_pkg, dpi_if, dpi_damp, dpi_lane.
//
//  channel | role  | moves
//  in_ch   | sink  | kind, vec_x/y/z, duration
//  out_ch  | source| pos/vel x/y/z, bad_step
//  cfg_ch  | sink  | register index, data
//
// Non-integrate items go from LOG to the result; integrating steps run log, exp,
// exp table of the damping unit, then three lane steps, the final damping scale
// beside the first. Next accept possible in the cycle after the result is taken.
// One item in flight; in_ch.ready is low until the result is taken.
// Reset clears state and registers to their reset values; cfg is always ready.
// A stalled out_ch holds the result in the lane registers.
module damped_particle_integrator_unit (
    input  logic clk,
    input  logic rst_n,
    dpi_in_if.sink     in_ch,
    dpi_out_if.source  out_ch,
    dpi_cfg_if.sink    cfg_ch
);

    dpi_pkg::state_t state_reg, state_next;
    logic [31:0] inv_mass_reg;
    logic [16:0] damping_reg;
    logic [31:0] accel_reg [3];
    logic [1:0]  kind_reg;
    logic [31:0] vec_reg [3];
    logic [23:0] dur_reg;
    logic        step_reg, bad_reg;

    logic [16:0] damp_eff;
    logic [16:0] factor;
    logic        accept;
    dpi_pkg::lane_ctl_t ctl;
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];

    assign accept = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign damp_eff = damping_reg[16] ? 17'd65536 : damping_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg <= dpi_pkg::ONE_Q16;
            damping_reg  <= 17'd65536;
            accel_reg[0] <= '0;
            accel_reg[1] <= '0;
            accel_reg[2] <= '0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                dpi_pkg::REG_INV_MASS: inv_mass_reg <= cfg_ch.data;
                dpi_pkg::REG_DAMPING:  damping_reg  <= cfg_ch.data[16:0];
                dpi_pkg::REG_ACCEL_X:  accel_reg[0] <= cfg_ch.data;
                dpi_pkg::REG_ACCEL_Y:  accel_reg[1] <= cfg_ch.data;
                dpi_pkg::REG_ACCEL_Z:  accel_reg[2] <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= in_ch.kind;
            vec_reg[0] <= in_ch.vec_x;
            vec_reg[1] <= in_ch.vec_y;
            vec_reg[2] <= in_ch.vec_z;
            dur_reg    <= in_ch.duration;
        end
    end

    // step / bad flags, decided at accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 1'b0;
            bad_reg  <= 1'b0;
        end
        else if (accept)
        begin
            step_reg <= (in_ch.kind == dpi_pkg::KIND_STEP) && (inv_mass_reg != 32'd0)
                        && (in_ch.duration != 24'd0);
            bad_reg  <= (in_ch.kind == dpi_pkg::KIND_STEP) && (inv_mass_reg != 32'd0)
                        && (in_ch.duration == 24'd0);
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dpi_pkg::ST_IDLE: if (accept) state_next = dpi_pkg::ST_LOG;
            dpi_pkg::ST_LOG:  state_next = step_reg ? dpi_pkg::ST_EXP : dpi_pkg::ST_OUT;
            dpi_pkg::ST_EXP:  state_next = dpi_pkg::ST_FAC;
            dpi_pkg::ST_FAC:  state_next = dpi_pkg::ST_P1;
            dpi_pkg::ST_P1:   state_next = dpi_pkg::ST_P2;
            dpi_pkg::ST_P2:   state_next = dpi_pkg::ST_P3;
            dpi_pkg::ST_P3:   state_next = dpi_pkg::ST_OUT;
            dpi_pkg::ST_OUT:  if (out_ch.ready) state_next = dpi_pkg::ST_IDLE;
            default:          state_next = dpi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dpi_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencer outputs
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            dpi_pkg::ST_LOG: ctl.load = 1'b1;
            dpi_pkg::ST_P1:  ctl.p1 = 1'b1;
            dpi_pkg::ST_P2:  ctl.p2 = 1'b1;
            dpi_pkg::ST_P3:  ctl.p3 = 1'b1;
            default: ;
        endcase
    end

    assign in_ch.ready = (state_reg == dpi_pkg::ST_IDLE);

    dpi_damp u_damp (
        .clk      (clk),
        .start    (state_reg == dpi_pkg::ST_LOG),
        .step_exp (state_reg == dpi_pkg::ST_EXP),
        .step_fac (state_reg == dpi_pkg::ST_P1),
        .damping  (damp_eff),
        .duration (dur_reg),
        .factor   (factor)
    );

    // three component lanes
    for (genvar c = 0; c < dpi_pkg::NumLanes; c++)
    begin : g_lane
        dpi_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .kind     (kind_reg),
            .do_step  (step_reg),
            .vec      (vec_reg[c]),
            .duration (dur_reg),
            .inv_mass (inv_mass_reg),
            .accel    (accel_reg[c]),
            .factor   (factor),
            .pos      (pos[c]),
            .vel      (vel[c])
        );
    end

    // merge lane state into the result
    assign out_ch.valid    = (state_reg == dpi_pkg::ST_OUT);
    assign out_ch.pos_x    = pos[0];
    assign out_ch.pos_y    = pos[1];
    assign out_ch.pos_z    = pos[2];
    assign out_ch.vel_x    = vel[0];
    assign out_ch.vel_y    = vel[1];
    assign out_ch.vel_z    = vel[2];
    assign out_ch.bad_step = bad_reg;

endmodule

// ----- design/dpi_checker.sv -----
// Port-level checker for the damped particle integrator, bound to the top level.
// Depends on dpi_if.
module dpi_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic bad_step
);

    // no new item while a result is pending
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while result pending");

    // result is held under stall
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bad_step))
        else $error("result dropped under stall");

    // accept leads to busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after accept");

endmodule

bind damped_particle_integrator_unit dpi_checker u_dpi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .bad_step  (out_ch.bad_step)
);

// ----- tb/dpi_tb_if.sv -----
// Testbench-side note: the channel interfaces come from design/dpi_if.sv.
// This file holds the small helper types the testbench shares. Depends on dpi_pkg.
`timescale 1ns / 1ps
package dpi_tb_pkg;

    typedef struct {
        dpi_pkg::kind_t     kind;
        logic signed [31:0] vec [3];
        logic [23:0]        duration;
    } particle_cmd_t;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic               bad_step;
    } particle_state_t;
endpackage

// ----- tb/damped_particle_integrator_unit_tb.sv -----
// Self-checking testbench for damped_particle_integrator_unit: random and directed
// particle commands, an in-file Q16.16 predictor and a scoreboard on the result channel.
// Depends on dpi_pkg, dpi_if, dpi_tb_pkg and the RTL.
`timescale 1ns / 1ps
module damped_particle_integrator_unit_tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dpi_in_if  in_ch ();
    dpi_out_if out_ch ();
    dpi_cfg_if cfg_ch ();

    damped_particle_integrator_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state and registers
    logic [31:0]        mdl_inv_mass;
    logic [16:0]        mdl_damping;
    logic signed [31:0] mdl_accel [3];
    logic signed [31:0] mdl_pos [3];
    logic signed [31:0] mdl_vel [3];
    logic signed [31:0] mdl_force [3];

    dpi_tb_pkg::particle_cmd_t   cmd_queue [$];
    dpi_tb_pkg::particle_state_t expected_states [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  error_count;
    bit  in_taken;
    bit  hold_start;
    bit  hold_active;

    localparam int unsigned LOG_TBL [17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109,
        34312, 38336, 42196, 45904, 49472, 52910, 56228, 59434, 62534, 65536};
    localparam int unsigned EXP_TBL [17] = '{65536, 68438, 71468, 74632, 77936, 81386,
        84990, 88752, 92682, 96785, 101070, 105545, 110218, 115098, 120193, 125515,
        131072};

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // round(a*b/2^16), half away from zero
    function automatic longint scale_q16(input logic signed [31:0] a, input longint b);
        longint unsigned mag;
        longint unsigned prod;
        mag = (a < 0) ? longint'(-longint'(a)) : longint'(a);
        prod = (mag * longint'(b) + 64'd32768) >> 16;
        return (a < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // damping^duration in Q1.16 via log2/exp2 tables
    function automatic longint damp_power(input logic [16:0] d, input logic [23:0] dur);
        int unsigned top;
        int unsigned mant;
        int unsigned frac;
        int unsigned idx;
        int unsigned rem;
        int unsigned lg;
        int unsigned mag_log;
        int unsigned fr;
        int unsigned g;
        int unsigned x;
        longint unsigned e;
        longint unsigned shift;
        if (d >= 17'd65536)
            return 65536;
        if (d == 17'd0)
            return 0;
        top = 15;
        while (d[top] == 1'b0)
            top--;
        mant = int'(d) << (16 - top);
        frac = mant - 65536;
        idx = frac >> 12;
        rem = frac & 4095;
        lg = LOG_TBL[idx] + (((LOG_TBL[idx + 1] - LOG_TBL[idx]) * rem + 2048) >> 12);
        mag_log = (16 - top) * 65536 - lg;
        e = (longint'(mag_log) * longint'(dur) + 32768) >> 16;
        fr = 32'(e & 64'hffff);
        g = 65536 - fr;
        idx = g >> 12;
        rem = g & 4095;
        if (idx >= 16)
            x = EXP_TBL[16];
        else
            x = EXP_TBL[idx] + (((EXP_TBL[idx + 1] - EXP_TBL[idx]) * rem + 2048) >> 12);
        shift = (e >> 16) + 1;
        if (shift >= 40)
            return 0;
        return (longint'(x) + (64'd1 << (shift - 1))) >> shift;
    endfunction

    function automatic dpi_tb_pkg::particle_state_t advance_particle(
        input dpi_tb_pkg::particle_cmd_t c);
        dpi_tb_pkg::particle_state_t r;
        longint             fac;
        logic signed [31:0] acc;
        logic signed [31:0] nv;
        r.bad_step = 1'b0;
        case (c.kind)
            dpi_pkg::KIND_FORCE:
                for (int i = 0; i < 3; i++)
                    mdl_force[i] = clamp32(longint'(mdl_force[i]) + longint'(c.vec[i]));
            dpi_pkg::KIND_POS:
                for (int i = 0; i < 3; i++)
                    mdl_pos[i] = c.vec[i];
            dpi_pkg::KIND_VEL:
                for (int i = 0; i < 3; i++)
                    mdl_vel[i] = c.vec[i];
            default:
                if (mdl_inv_mass != 0)
                begin
                    if (c.duration == 0)
                        r.bad_step = 1'b1;
                    else
                    begin
                        fac = damp_power(mdl_damping, c.duration);
                        for (int i = 0; i < 3; i++)
                        begin
                            mdl_pos[i] = clamp32(longint'(mdl_pos[i])
                                + scale_q16(mdl_vel[i], c.duration));
                            acc = clamp32(longint'(mdl_accel[i]) + longint'(clamp32(
                                scale_q16(mdl_force[i], longint'(mdl_inv_mass)))));
                            nv = clamp32(longint'(mdl_vel[i]) + scale_q16(acc, c.duration));
                            mdl_vel[i] = clamp32(scale_q16(nv, fac));
                            mdl_force[i] = 0;
                        end
                    end
                end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            r.pos[i] = mdl_pos[i];
            r.vel[i] = mdl_vel[i];
        end
        return r;
    endfunction

    // input transaction taken at the last rising edge
    always @(posedge clk)
        in_taken <= rst_n && in_ch.valid && in_ch.ready;

    // driver: one transaction from the queue, changed on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_taken)
        begin
            if (in_taken)
                void'(cmd_queue.pop_front());
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid    <= 1'b1;
                in_ch.kind     <= cmd_queue[0].kind;
                in_ch.vec_x    <= cmd_queue[0].vec[0];
                in_ch.vec_y    <= cmd_queue[0].vec[1];
                in_ch.vec_z    <= cmd_queue[0].vec[2];
                in_ch.duration <= cmd_queue[0].duration;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // predictor runs on each accepted input transaction
    always @(posedge clk)
    begin
        dpi_tb_pkg::particle_cmd_t c;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            c.kind = dpi_pkg::kind_t'(in_ch.kind);
            c.vec[0] = in_ch.vec_x;
            c.vec[1] = in_ch.vec_y;
            c.vec[2] = in_ch.vec_z;
            c.duration = in_ch.duration;
            expected_states.push_back(advance_particle(c));
        end
    end

    // long receiver hold-off, counted here once requested
    initial
    begin
        hold_active = 1'b0;
        wait (hold_start);
        hold_active = 1'b1;
        repeat (300) @(posedge clk);
        hold_active = 1'b0;
    end

    // receiver ready
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_active)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        dpi_tb_pkg::particle_state_t want;
        logic [31:0] got [7];
        logic [31:0] exp_v [7];
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_states.size() == 0)
            begin
                $display("%0t: unexpected result transaction", $time);
                error_count++;
            end
            else
            begin
                want = expected_states.pop_front();
                got = '{out_ch.pos_x, out_ch.pos_y, out_ch.pos_z,
                        out_ch.vel_x, out_ch.vel_y, out_ch.vel_z, 32'(out_ch.bad_step)};
                exp_v = '{want.pos[0], want.pos[1], want.pos[2],
                          want.vel[0], want.vel[1], want.vel[2], 32'(want.bad_step)};
                for (int i = 0; i < 7; i++)
                    if (got[i] !== exp_v[i])
                    begin
                        $display("%0t: field %0d expected %h actual %h",
                                 $time, i, exp_v[i], got[i]);
                        error_count++;
                    end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            dpi_pkg::REG_INV_MASS: mdl_inv_mass = val;
            dpi_pkg::REG_DAMPING:  mdl_damping = val[16:0];
            dpi_pkg::REG_ACCEL_X:  mdl_accel[0] = val;
            dpi_pkg::REG_ACCEL_Y:  mdl_accel[1] = val;
            dpi_pkg::REG_ACCEL_Z:  mdl_accel[2] = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic queue_cmd(input dpi_pkg::kind_t k, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z,
                             input logic [23:0] dur);
        dpi_tb_pkg::particle_cmd_t c;
        c.kind = k;
        c.vec[0] = x;
        c.vec[1] = y;
        c.vec[2] = z;
        c.duration = dur;
        cmd_queue.push_back(c);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(131072);
            3: return -$urandom_range(131072);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] rand_duration();
        case ($urandom_range(7))
            0: return 24'hffffff;
            1: return 24'd0;
            2: return $urandom_range(16);
            default: return $urandom_range(65536);
        endcase
    endfunction

    // queue a phase of random commands
    task automatic run_random(input int count);
        dpi_pkg::kind_t k;
        for (int n = 0; n < count; n++)
        begin
            k = dpi_pkg::kind_t'($urandom_range(3));
            queue_cmd(k, rand_word(), rand_word(), rand_word(), rand_duration());
        end
    endtask

    // wait until every queued transaction has come back
    task automatic drain();
        while (cmd_queue.size() != 0 || in_ch.valid || expected_states.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_config();
        write_reg(dpi_pkg::REG_INV_MASS,
                  ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(262144));
        write_reg(dpi_pkg::REG_DAMPING, $urandom_range(70000));
        write_reg(dpi_pkg::REG_ACCEL_X, rand_word());
        write_reg(dpi_pkg::REG_ACCEL_Y, rand_word());
        write_reg(dpi_pkg::REG_ACCEL_Z, rand_word());
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.kind = dpi_pkg::KIND_FORCE;
        in_ch.vec_x = '0;
        in_ch.vec_y = '0;
        in_ch.vec_z = '0;
        in_ch.duration = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = dpi_pkg::REG_INV_MASS;
        cfg_ch.data = '0;
        mdl_inv_mass = dpi_pkg::ONE_Q16;
        mdl_damping = 17'd65536;
        for (int i = 0; i < 3; i++)
        begin
            mdl_accel[i] = 0;
            mdl_pos[i] = 0;
            mdl_vel[i] = 0;
            mdl_force[i] = 0;
        end
        send_idle_pct = 35;
        recv_idle_pct = 54;
        error_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every kind, field extremes, zero duration, overflow
        queue_cmd(dpi_pkg::KIND_POS, 32'h7fffffff, 32'h80000000, 32'd0, 24'd0);
        queue_cmd(dpi_pkg::KIND_VEL, 32'h00010000, 32'hffff0000, 32'h7fffffff, 24'd0);
        queue_cmd(dpi_pkg::KIND_FORCE, 32'h7fffffff, 32'h80000000, 32'h00020000, 24'hffffff);
        queue_cmd(dpi_pkg::KIND_FORCE, 32'h7fffffff, 32'h80000000, 32'h00020000, 24'd0);
        queue_cmd(dpi_pkg::KIND_STEP, 32'd0, 32'd0, 32'd0, 24'd0);
        queue_cmd(dpi_pkg::KIND_STEP, 32'hffffffff, 32'hffffffff, 32'hffffffff, 24'hffffff);
        queue_cmd(dpi_pkg::KIND_STEP, 32'd0, 32'd0, 32'd0, 24'd1);
        queue_cmd(dpi_pkg::KIND_VEL, 32'h00050000, 32'hfffb0000, 32'd12345, 24'd0);
        queue_cmd(dpi_pkg::KIND_STEP, 32'd0, 32'd0, 32'd0, 24'h010000);
        drain();

        // infinite mass, damping above one and zero, extreme accelerations
        write_reg(dpi_pkg::REG_INV_MASS, 32'd0);
        write_reg(dpi_pkg::REG_DAMPING, 17'h1ffff);
        queue_cmd(dpi_pkg::KIND_FORCE, 32'h00010000, 32'd1, 32'd2, 24'd0);
        queue_cmd(dpi_pkg::KIND_STEP, 32'd0, 32'd0, 32'd0, 24'd0);
        queue_cmd(dpi_pkg::KIND_STEP, 32'd0, 32'd0, 32'd0, 24'h008000);
        drain();
        write_reg(dpi_pkg::REG_INV_MASS, 32'hffffffff);
        write_reg(dpi_pkg::REG_DAMPING, 17'd0);
        write_reg(dpi_pkg::REG_ACCEL_X, 32'h7fffffff);
        write_reg(dpi_pkg::REG_ACCEL_Y, 32'h80000000);
        write_reg(dpi_pkg::REG_ACCEL_Z, 32'd0);
        queue_cmd(dpi_pkg::KIND_VEL, 32'h00100000, 32'h00100000, 32'h00100000, 24'd0);
        queue_cmd(dpi_pkg::KIND_STEP, 32'd0, 32'd0, 32'd0, 24'h000100);
        drain();
        write_reg(dpi_pkg::REG_DAMPING, 17'd1);
        queue_cmd(dpi_pkg::KIND_STEP, 32'd0, 32'd0, 32'd0, 24'hffffff);
        queue_cmd(dpi_pkg::KIND_STEP, 32'd0, 32'd0, 32'd0, 24'd1);
        drain();

        // random phases across idling modes; long receiver stall in the middle
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 54 : 0;
            recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 35 : 0;
            for (int s = 0; s < 4; s++)
            begin
                random_config();
                run_random(125);
                if (ph == 1 && s == 0)
                    hold_start = 1'b1;
                drain();
            end
        end

        // nominal settings to finish
        write_reg(dpi_pkg::REG_INV_MASS, dpi_pkg::ONE_Q16);
        write_reg(dpi_pkg::REG_DAMPING, 17'd65536);
        run_random(20);
        drain();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/dpi_pkg.sv
design/dpi_if.sv
design/dpi_damp.sv
design/dpi_lane.sv
design/damped_particle_integrator_unit.sv
design/dpi_checker.sv
tb/dpi_tb_if.sv
tb/damped_particle_integrator_unit_tb.sv
